@@ rtl/gfct_pkg.sv @@
// ----------------------------------------------------------------------------
// gfct_pkg
// Shared types and constants for the gated four-channel timer unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gfct_pkg;

  // counter geometry
  localparam int COUNT_WIDTH = 16;
  localparam int CNT_EXT_W   = COUNT_WIDTH + 1;
  localparam int MODE_W      = 12;
  localparam int CMD_W       = 4;
  localparam int IDX_W       = 2;
  localparam int DATA_W      = 32;
  localparam int IRQ_W       = 4;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [CNT_EXT_W-1:0]   count_ext_t;
  typedef logic [MODE_W-1:0]      mode_bits_t;
  typedef logic [CMD_W-1:0]       cmd_t;

  // command codes
  localparam cmd_t CMD_TICK      = 4'd0;
  localparam cmd_t CMD_WR_COUNT  = 4'd1;
  localparam cmd_t CMD_WR_MODE   = 4'd2;
  localparam cmd_t CMD_WR_TARGET = 4'd3;
  localparam cmd_t CMD_WR_HOLD   = 4'd4;
  localparam cmd_t CMD_RD_COUNT  = 4'd5;
  localparam cmd_t CMD_HBL_START = 4'd6;
  localparam cmd_t CMD_HBL_END   = 4'd7;
  localparam cmd_t CMD_VBL_START = 4'd8;
  localparam cmd_t CMD_VBL_END   = 4'd9;

  // mode bit positions
  localparam int MB_GATE = 2;
  localparam int MB_GATS = 3;
  localparam int MB_GATM_LO = 4;
  localparam int MB_GATM_HI = 5;
  localparam int MB_ZRET = 6;
  localparam int MB_CUE  = 7;
  localparam int MB_CMPE = 8;
  localparam int MB_OVFE = 9;
  localparam int MB_EQUF = 10;
  localparam int MB_OVFF = 11;

  // clock select codes
  localparam logic [1:0] CLKS_DIV2   = 2'd0;
  localparam logic [1:0] CLKS_DIV32  = 2'd1;
  localparam logic [1:0] CLKS_DIV512 = 2'd2;
  localparam logic [1:0] CLKS_HBLANK = 2'd3;

  // gate modes
  localparam logic [1:0] GM_RUN_LOW   = 2'd0;
  localparam logic [1:0] GM_RST_START = 2'd1;
  localparam logic [1:0] GM_RST_END   = 2'd2;
  localparam logic [1:0] GM_RST_BOTH  = 2'd3;

  // mode value that disables the gate
  localparam logic [3:0] MODE_GATE_OFF = 4'h7;

  localparam count_ext_t WRAP_STEP    = 17'h10000;
  localparam count_t     DIV_2        = 16'd2;
  localparam count_t     DIV_32       = 16'd32;
  localparam count_t     DIV_512      = 16'd512;
  localparam count_t     HBLANK_RESET = 16'd4096;
  localparam count_t     TARGET_RESET = 16'hffff;

  // one accepted item as seen by the channels
  typedef struct packed {
    cmd_t              command;
    logic [IDX_W-1:0]  timer_index;
    logic [DATA_W-1:0] write_data;
  } op_t;

  // per-channel status back to the top level
  typedef struct packed {
    logic   irq;
    count_t count_low;
  } chan_stat_t;

endpackage

`default_nettype wire

@@ rtl/gfct_in_if.sv @@
// ----------------------------------------------------------------------------
// gfct_in_if
// Command channel: valid/ready handshake carrying one command word.
// ----------------------------------------------------------------------------
`default_nettype none

interface gfct_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  command;
  logic [1:0]  timer_index;
  logic [31:0] write_data;

  modport source (output valid, command, timer_index, write_data, input ready);
  modport sink   (input valid, command, timer_index, write_data, output ready);
endinterface

`default_nettype wire

@@ rtl/gfct_out_if.sv @@
// ----------------------------------------------------------------------------
// gfct_out_if
// Result channel: valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface gfct_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;
  logic [3:0]  irq_pulses;

  modport source (output valid, read_data, irq_pulses, input ready);
  modport sink   (input valid, read_data, irq_pulses, output ready);
endinterface

`default_nettype wire

@@ rtl/gfct_channel.sv @@
// ----------------------------------------------------------------------------
// gfct_channel
// One timer: prescaler, count, target, mode, hold and gate enable, updated
// in a single pass for each processed word.
// ----------------------------------------------------------------------------
`default_nettype none

module gfct_channel #(
  parameter int IDX = 0
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   step,
  input  gfct_pkg::op_t         op,
  input  gfct_pkg::count_t      hblank_period,
  output gfct_pkg::chan_stat_t  status
);
  import gfct_pkg::*;

  count_ext_t  count, count_next;
  count_ext_t  target, target_next;
  mode_bits_t  mode, mode_next;
  count_t      phase, phase_next;
  logic [DATA_W-1:0] hold, hold_next;
  logic        gate, gate_next;
  logic        irq;

  count_t      divisor;
  count_ext_t  phase_inc;
  logic        wrap;
  logic        addressed;

  // prescaler divisor and wrap detect
  always_comb begin
    case (mode[1:0])
      CLKS_DIV2:   divisor = DIV_2;
      CLKS_DIV32:  divisor = DIV_32;
      CLKS_DIV512: divisor = DIV_512;
      default:     divisor = hblank_period;
    endcase
    phase_inc = {1'b0, phase} + 17'd1;
    wrap      = phase_inc >= {1'b0, divisor};
  end

  assign addressed = (op.timer_index == IDX[IDX_W-1:0]);

  // next state for every command
  always_comb begin
    count_ext_t cnt_w;
    count_ext_t tgt_w;
    mode_bits_t mode_w;
    logic       edge_sel;
    logic       is_start;
    logic [1:0] gm;

    count_next  = count;
    target_next = target;
    mode_next   = mode;
    phase_next  = phase;
    hold_next   = hold;
    gate_next   = gate;
    irq         = 1'b0;
    cnt_w       = count;
    tgt_w       = target;
    mode_w      = mode;
    edge_sel    = (op.command == CMD_VBL_START) || (op.command == CMD_VBL_END);
    is_start    = (op.command == CMD_HBL_START) || (op.command == CMD_VBL_START);
    gm          = mode[MB_GATM_HI:MB_GATM_LO];

    if (step) begin
      case (op.command)
        CMD_TICK: begin
          phase_next = wrap ? '0 : phase_inc[COUNT_WIDTH-1:0];
          if (wrap && mode[MB_CUE]) begin
            cnt_w = count + 17'd1;
          end
          if (mode[MB_CUE]) begin
            // compare match
            if (cnt_w == tgt_w && mode[MB_CMPE]) begin
              mode_w[MB_EQUF] = 1'b1;
              irq = 1'b1;
              if (mode[MB_ZRET]) begin
                tgt_w = {1'b0, tgt_w[COUNT_WIDTH-1:0]};
                cnt_w = '0;
              end else begin
                tgt_w = tgt_w + WRAP_STEP;
              end
            end
            // overflow past 16 bits
            if (cnt_w[COUNT_WIDTH]) begin
              if (mode[MB_OVFE]) begin
                mode_w[MB_OVFF] = 1'b1;
                irq = 1'b1;
              end
              cnt_w = '0;
              tgt_w = {1'b0, tgt_w[COUNT_WIDTH-1:0]};
            end
          end
          count_next  = cnt_w;
          target_next = tgt_w;
          mode_next   = mode_w;
        end
        CMD_WR_COUNT: begin
          if (addressed) begin
            count_next  = {1'b0, op.write_data[COUNT_WIDTH-1:0]};
            target_next = {1'b0, target[COUNT_WIDTH-1:0]};
            phase_next  = '0;
          end
        end
        CMD_WR_MODE: begin
          if (addressed) begin
            // write-one-to-clear flags
            mode_w[MB_EQUF] = mode[MB_EQUF] & ~op.write_data[MB_EQUF];
            mode_w[MB_OVFF] = mode[MB_OVFF] & ~op.write_data[MB_OVFF];
            if (op.write_data[MB_CUE] && !mode[MB_CUE]) begin
              phase_next = '0;
            end
            mode_w[MB_OVFE:0] = op.write_data[MB_OVFE:0];
            if (mode_w[3:0] == MODE_GATE_OFF) begin
              gate_next = 1'b0;
              mode_w[MB_CUE] = 1'b0;
            end else if (mode_w[MB_GATE]) begin
              gate_next = 1'b1;
              mode_w[MB_CUE]  = 1'b0;
              mode_w[MB_EQUF] = 1'b0;
              mode_w[MB_OVFF] = 1'b0;
              cnt_w = '0;
              phase_next = '0;
            end else begin
              gate_next = 1'b0;
            end
            // drop a re-armed target that is still ahead of the count
            if (target[COUNT_WIDTH] &&
                ({1'b0, target[COUNT_WIDTH-1:0]} > cnt_w)) begin
              target_next = {1'b0, target[COUNT_WIDTH-1:0]};
            end
            mode_next  = mode_w;
            count_next = cnt_w;
          end
        end
        CMD_WR_TARGET: begin
          if (addressed) begin
            tgt_w = {1'b0, op.write_data[COUNT_WIDTH-1:0]};
            if (tgt_w <= count) begin
              tgt_w = tgt_w + WRAP_STEP;
            end
            target_next = tgt_w;
          end
        end
        CMD_WR_HOLD: begin
          if (addressed) begin
            hold_next = op.write_data;
          end
        end
        CMD_HBL_START, CMD_HBL_END, CMD_VBL_START, CMD_VBL_END: begin
          if (gate && (mode[MB_GATS] == edge_sel)) begin
            if (gm == GM_RUN_LOW) begin
              phase_next = '0;
              if (is_start) begin
                count_next = {1'b0, count[COUNT_WIDTH-1:0]};
                mode_w[MB_CUE] = 1'b0;
              end else begin
                mode_w[MB_CUE] = 1'b1;
              end
              mode_next = mode_w;
            end else if ((gm == GM_RST_START && is_start) ||
                         (gm == GM_RST_END && !is_start) || gm == GM_RST_BOTH) begin
              mode_w[MB_CUE]  = 1'b1;
              mode_w[MB_EQUF] = 1'b0;
              mode_w[MB_OVFF] = 1'b0;
              mode_next  = mode_w;
              count_next = '0;
              phase_next = '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      target <= {1'b0, TARGET_RESET};
      mode   <= '0;
      phase  <= '0;
      hold   <= '0;
      gate   <= 1'b0;
    end else begin
      count  <= count_next;
      target <= target_next;
      mode   <= mode_next;
      phase  <= phase_next;
      hold   <= hold_next;
      gate   <= gate_next;
    end
  end

  assign status.irq       = irq;
  assign status.count_low = count[COUNT_WIDTH-1:0];

endmodule

`default_nettype wire

@@ rtl/gated_four_channel_timer_unit.sv @@
// ----------------------------------------------------------------------------
// gated_four_channel_timer_unit
// Up to four 16-bit interval timers with prescaler, compare, overflow and
// hblank/vblank gating, driven by a stream of command words.
// ----------------------------------------------------------------------------
// The unit accepts one command word every clock cycle while out_ch does not stall
// it, and returns exactly one result word per command: a word is captured in the
// input stage, every timer computes its next state from it in one pass, and the
// read data and interrupt bits land in the result register. The result register
// decouples the two sides, so a command is still taken into an empty input stage
// while a finished result waits for ready. The user writes the line period divisor
// through cfg_we/cfg_wdata only while no command is in flight; the block does not enforce it.
`default_nettype none

module gated_four_channel_timer_unit #(
  parameter int NUM_TIMERS = 4
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_we,
  input  wire  [15:0] cfg_wdata,
  gfct_in_if.sink     in_ch,
  gfct_out_if.source  out_ch
);
  import gfct_pkg::*;

  count_t     hblank_period;
  logic       stage_valid;
  op_t        stage_op;
  logic       fire;
  logic       out_valid;
  count_t     read_data;
  logic [IRQ_W-1:0] irq_pulses;
  count_t     rd_mux;
  logic [IRQ_W-1:0] irq_vec;
  chan_stat_t ch_stat [NUM_TIMERS];

  // line period register
  always_ff @(posedge clk) begin
    if (rst) begin
      hblank_period <= HBLANK_RESET;
    end else if (cfg_we) begin
      hblank_period <= cfg_wdata;
    end
  end

  // handshake
  assign fire        = stage_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !stage_valid || fire;

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ch.ready) begin
      stage_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      stage_op.command     <= in_ch.command;
      stage_op.timer_index <= in_ch.timer_index;
      stage_op.write_data  <= in_ch.write_data;
    end
  end

  // timer channels
  for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_chan
    gfct_channel #(.IDX(g)) u_chan (
      .clk           (clk),
      .rst           (rst),
      .step          (fire),
      .op            (stage_op),
      .hblank_period (hblank_period),
      .status        (ch_stat[g])
    );
  end

  // read mux and interrupt gather
  always_comb begin
    rd_mux  = '0;
    irq_vec = '0;
    for (int t = 0; t < NUM_TIMERS; t++) begin
      if (stage_op.command == CMD_RD_COUNT &&
          stage_op.timer_index == t[IDX_W-1:0]) begin
        rd_mux = ch_stat[t].count_low;
      end
      irq_vec[t] = ch_stat[t].irq;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      read_data  <= rd_mux;
      irq_pulses <= irq_vec;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.read_data  = read_data;
  assign out_ch.irq_pulses = irq_pulses;

  // interrupts only come out of a tick
  a_irq_tick_only: assert property (@(posedge clk) disable iff (rst)
    fire && stage_op.command != CMD_TICK |-> irq_vec == '0)
    else $error("interrupt raised outside a tick");

  // read data is zero for anything but a count read
  a_rd_zero: assert property (@(posedge clk) disable iff (rst)
    fire && stage_op.command != CMD_RD_COUNT |=> out_ch.read_data == '0)
    else $error("read data nonzero on a non-read command");

  // a processed word always produces a pending result
  a_fire_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_ch.valid)
    else $error("result lost after processing");

  // a stalled word stays in the input stage unchanged
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !fire |=> stage_valid && $stable(stage_op))
    else $error("input stage changed while stalled");

endmodule

`default_nettype wire
